[rtl/core/line_pd_dual_motor_drive_top_assert.svh]
// assertion macros for the line follower drive block
`ifndef LINE_PD_DUAL_MOTOR_DRIVE_TOP_ASSERT_SVH
`define LINE_PD_DUAL_MOTOR_DRIVE_TOP_ASSERT_SVH
`ifndef SYNTH
`define LPDD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define LPDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPDD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define LPDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/lpdd_pkg.sv]
package lpdd_pkg;

  localparam int ERR_W  = 16;          // q8.8 input and register fields
  localparam int DER_W  = 17;          // error difference
  localparam int CW     = 34;          // kp*e + kd*d
  localparam int TW     = 35;          // wheel targets
  localparam int BSW    = 37;          // boosted targets
  localparam int XW     = 38;          // boosted target plus correction
  localparam int MUL_LB = 20;          // low slice of the wide operand
  localparam int MUL_AW = MUL_LB + 1;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int NW     = 56;          // pwm numerator
  localparam int PWMW   = 17;          // saturated pwm, full scale up to 65535
  localparam int CMP_W  = 11;          // compare and drive fields

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_DERIV_GAIN   = 3'd1,
    REG_DERIV_IVL    = 3'd2,
    REG_BASE_SPEED   = 3'd3,
    REG_LEFT_SLOPE   = 3'd4,
    REG_LEFT_OFFSET  = 3'd5,
    REG_RIGHT_SLOPE  = 3'd6,
    REG_RIGHT_OFFSET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
  } mul_req_t;

endpackage

[rtl/core/lpdd_mul.sv]
module lpdd_mul import lpdd_pkg::*; (
  input  logic                     clk,
  input  mul_req_t                 req,
  output logic signed [MUL_PW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= $signed(req.a) * $signed(req.b);
  end

endmodule

[rtl/core/line_pd_dual_motor_drive_top.sv]
// pd line follower with differential drive, one shared 21x17 multiplier
// out_valid rises from the decode state once both wheels are done; in_stall holds off
// new beats until the tick finishes, as the sequencer steps the single multiplier
// through kp, kd and two partial products per wheel, and decode waits on out_stall
// reset: synchronous, active high; controller state, config and derivative registers and out_valid clear to 0
`include "line_pd_dual_motor_drive_top_assert.svh"
module line_pd_dual_motor_drive_top import lpdd_pkg::*; #(
  parameter int PWM_FULL_SCALE = 1000,
  parameter int FRAC_BITS      = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [31:0]             now_ms,
  input  logic signed [ERR_W-1:0] line_error,
  input  logic signed [ERR_W-1:0] left_speed,
  input  logic signed [ERR_W-1:0] right_speed,
  input  logic                    driving,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    write_valid,
  output logic [CMP_W-1:0]        right_fwd_compare,
  output logic [CMP_W-1:0]        right_rev_compare,
  output logic [CMP_W-1:0]        left_fwd_compare,
  output logic [CMP_W-1:0]        left_rev_compare,
  output logic signed [CMP_W-1:0] left_drive,
  output logic signed [CMP_W-1:0] right_drive,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  localparam int F2 = 2 * FRAC_BITS;
  localparam logic signed [NW-1:0]   RND_BIAS = (NW'(1) <<< F2) - NW'(1);
  localparam logic signed [NW-1:0]   FULL_NW  = NW'(PWM_FULL_SCALE);
  localparam logic signed [PWMW-1:0] FULL     = PWMW'(PWM_FULL_SCALE);

  typedef enum logic [3:0] {
    S_IDLE, S_KP, S_KD, S_CSUM, S_TGT, S_BST, S_XSUM,
    S_MLO, S_MHI, S_MACC, S_RND, S_SAT, S_DEC
  } state_t;

  state_t state;

  logic signed [ERR_W-1:0] prop_gain, deriv_gain, base_speed;
  logic [15:0]             deriv_interval_ms;
  logic [15:0]             left_slope, left_offset, right_slope, right_offset;

  logic [31:0]             last_sample_time;
  logic signed [ERR_W-1:0] last_error;
  logic signed [DER_W-1:0] deriv_term;
  logic                    was_driving;

  logic signed [ERR_W-1:0] err_q, lsp_q, rsp_q;
  logic                    drv_q;
  logic signed [CW-1:0]    corr;
  logic signed [TW-1:0]    tgt_l, tgt_r;
  logic signed [BSW-1:0]   bst_l, bst_r;
  logic signed [XW-1:0]    x_l, x_r;
  logic signed [NW-1:0]    num, quot;
  logic signed [PWMW-1:0]  pwm_l, pwm_r;
  logic                    side;

  mul_req_t                req;
  logic signed [MUL_PW-1:0] prod;

  logic                    in_beat;
  logic [31:0]             elapsed;
  logic signed [TW-1:0]    base_q;
  logic signed [BSW-1:0]   lsp_sc, rsp_sc;
  logic signed [XW-1:0]    x_sel;
  logic [15:0]             slope_sel, offset_sel;
  logic signed [NW-1:0]    off_sh, num_rnd, bias;
  logic signed [PWMW-1:0]  pwm_sat;

  logic                    wv_d;
  logic [CMP_W-1:0]        rf_d, rr_d, lf_d, lr_d;
  logic signed [PWMW:0]    full_e, pl_e, pr_e, full_m_pr, full_m_pl, full_p_pr, full_p_pl;

  lpdd_mul u_mul (
    .clk  (clk),
    .req  (req),
    .prod (prod)
  );

  assign in_stall = (state != S_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign elapsed  = now_ms - last_sample_time;

  assign base_q = $signed({{(TW-ERR_W){base_speed[ERR_W-1]}}, base_speed}) <<< FRAC_BITS;
  assign lsp_sc = $signed({{(BSW-ERR_W){lsp_q[ERR_W-1]}}, lsp_q}) <<< FRAC_BITS;
  assign rsp_sc = $signed({{(BSW-ERR_W){rsp_q[ERR_W-1]}}, rsp_q}) <<< FRAC_BITS;

  assign x_sel      = side ? x_r : x_l;
  assign slope_sel  = side ? right_slope : left_slope;
  assign offset_sel = side ? right_offset : left_offset;
  assign off_sh     = $signed(NW'(offset_sel) << F2);

  // truncate toward zero: negative numerators get the divisor less one added
  assign bias    = num[NW-1] ? RND_BIAS : {NW{1'b0}};
  assign num_rnd = num + bias;

  always_comb begin
    if (quot > FULL_NW) begin
      pwm_sat = FULL;
    end else if (quot < -FULL_NW) begin
      pwm_sat = -FULL;
    end else begin
      pwm_sat = PWMW'(quot);
    end
  end

  always_comb begin
    req.a = '0;
    req.b = '0;
    unique case (state)
      S_KP: begin
        req.a = MUL_AW'(err_q);
        req.b = MUL_BW'(prop_gain);
      end
      S_KD: begin
        req.a = MUL_AW'(deriv_term);
        req.b = MUL_BW'(deriv_gain);
      end
      S_MLO: begin
        req.a = $signed({1'b0, x_sel[MUL_LB-1:0]});
        req.b = $signed({1'b0, slope_sel});
      end
      S_MHI: begin
        req.a = MUL_AW'(x_sel >>> MUL_LB);
        req.b = $signed({1'b0, slope_sel});
      end
      default: begin
        req.a = '0;
        req.b = '0;
      end
    endcase
  end

  // bridge decode
  assign full_e    = (PWMW+1)'(FULL);
  assign pl_e      = (PWMW+1)'(pwm_l);
  assign pr_e      = (PWMW+1)'(pwm_r);
  assign full_m_pr = full_e - pr_e;
  assign full_m_pl = full_e - pl_e;
  assign full_p_pr = full_e + pr_e;
  assign full_p_pl = full_e + pl_e;

  always_comb begin
    wv_d = 1'b0;
    rf_d = '0;
    rr_d = '0;
    lf_d = '0;
    lr_d = '0;
    priority if (!drv_q && was_driving) begin
      wv_d = 1'b1;
      rf_d = full_e[CMP_W-1:0];
      rr_d = full_e[CMP_W-1:0];
      lf_d = full_e[CMP_W-1:0];
      lr_d = full_e[CMP_W-1:0];
    end else if (drv_q) begin
      priority if (pwm_l[PWMW-1] && pwm_r[PWMW-1]) begin
        wv_d = 1'b0;
      end else if (pwm_l[PWMW-1] || (pwm_l == '0)) begin
        wv_d = 1'b1;
        rf_d = full_m_pr[CMP_W-1:0];
        rr_d = full_e[CMP_W-1:0];
        lf_d = full_e[CMP_W-1:0];
        lr_d = full_p_pl[CMP_W-1:0];
      end else if (pwm_r[PWMW-1]) begin
        wv_d = 1'b1;
        rf_d = full_e[CMP_W-1:0];
        rr_d = full_p_pr[CMP_W-1:0];
        lf_d = full_m_pl[CMP_W-1:0];
        lr_d = full_e[CMP_W-1:0];
      end else begin
        wv_d = 1'b1;
        rf_d = full_m_pr[CMP_W-1:0];
        rr_d = full_e[CMP_W-1:0];
        lf_d = full_m_pl[CMP_W-1:0];
        lr_d = full_e[CMP_W-1:0];
      end
    end else begin
      wv_d = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      side              <= 1'b0;
      prop_gain         <= '0;
      deriv_gain        <= '0;
      deriv_interval_ms <= '0;
      base_speed        <= '0;
      left_slope        <= '0;
      left_offset       <= '0;
      right_slope       <= '0;
      right_offset      <= '0;
      last_sample_time  <= '0;
      last_error        <= '0;
      deriv_term        <= '0;
      was_driving       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_PROP_GAIN:    prop_gain         <= $signed(cfg_data);
          REG_DERIV_GAIN:   deriv_gain        <= $signed(cfg_data);
          REG_DERIV_IVL:    deriv_interval_ms <= cfg_data;
          REG_BASE_SPEED:   base_speed        <= $signed(cfg_data);
          REG_LEFT_SLOPE:   left_slope        <= cfg_data;
          REG_LEFT_OFFSET:  left_offset       <= cfg_data;
          REG_RIGHT_SLOPE:  right_slope       <= cfg_data;
          REG_RIGHT_OFFSET: right_offset      <= cfg_data;
        endcase
      end

      // the decode state raises out_valid itself when the old beat leaves
      if (out_valid && !out_stall && (state != S_DEC)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            err_q <= line_error;
            lsp_q <= left_speed;
            rsp_q <= right_speed;
            drv_q <= driving;
            // derivative refresh on wrapping time, driving or not
            if (elapsed > {16'd0, deriv_interval_ms}) begin
              deriv_term       <= DER_W'(line_error) - DER_W'(last_error);
              last_error       <= line_error;
              last_sample_time <= now_ms;
            end
            state <= S_KP;
          end
        end
        S_KP: state <= S_KD;
        S_KD: begin
          corr  <= CW'(prod);
          state <= S_CSUM;
        end
        S_CSUM: begin
          corr  <= corr + CW'(prod);
          state <= S_TGT;
        end
        S_TGT: begin
          tgt_l <= base_q + TW'(corr);
          tgt_r <= base_q - TW'(corr);
          state <= S_BST;
        end
        S_BST: begin
          bst_l <= (BSW'(tgt_l) <<< 1) - lsp_sc;
          bst_r <= (BSW'(tgt_r) <<< 1) - rsp_sc;
          state <= S_XSUM;
        end
        S_XSUM: begin
          // correction goes in once more ahead of the slope
          x_l   <= XW'(bst_l) + XW'(corr);
          x_r   <= XW'(bst_r) - XW'(corr);
          side  <= 1'b0;
          state <= S_MLO;
        end
        S_MLO: state <= S_MHI;
        S_MHI: begin
          num   <= NW'(prod) + off_sh;
          state <= S_MACC;
        end
        S_MACC: begin
          num   <= num + (NW'(prod) <<< MUL_LB);
          state <= S_RND;
        end
        S_RND: begin
          quot  <= num_rnd >>> F2;
          state <= S_SAT;
        end
        S_SAT: begin
          if (side) begin
            pwm_r <= pwm_sat;
            state <= S_DEC;
          end else begin
            pwm_l <= pwm_sat;
            side  <= 1'b1;
            state <= S_MLO;
          end
        end
        S_DEC: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            write_valid       <= wv_d;
            right_fwd_compare <= rf_d;
            right_rev_compare <= rr_d;
            left_fwd_compare  <= lf_d;
            left_rev_compare  <= lr_d;
            left_drive        <= pwm_l[CMP_W-1:0];
            right_drive       <= pwm_r[CMP_W-1:0];
            was_driving       <= drv_q;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LPDD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_beat, in_stall, "accepted beat did not start a tick")
  `LPDD_ASSERT_SAME(a_hold_is_zero, clk, rst, out_valid && !write_valid, (right_fwd_compare == '0) && (right_rev_compare == '0) && (left_fwd_compare == '0) && (left_rev_compare == '0), "hold result carries compares")
  `LPDD_ASSERT_NEXT(a_dec_waits, clk, rst, (state == S_DEC) && out_valid && out_stall, state == S_DEC, "result overwrote a waiting beat")

endmodule
